### rtl/ptbts_pkg.sv
// shared widths, reset values, band table and clamp for the pan/tilt tracking servo
`timescale 1ns / 1ps

package ptbts_pkg;

  localparam int PULSE_BITS = 10;
  localparam int OUT_W      = 10;
  // signed working width for read-back plus step, wide enough for any pulse width
  localparam int CALC_W     = 18;

  localparam logic [PULSE_BITS-1:0] PULSE_MAX   = {PULSE_BITS{1'b1}};
  localparam logic [PULSE_BITS-1:0] PULSE_RESET = PULSE_BITS'(166);

  localparam logic [2:0]  SIG_RESET       = 3'd1;
  localparam logic [15:0] LOCK_RESET      = 16'd500;
  localparam logic [7:0]  TILT_HIGH_RESET = 8'd125;
  localparam logic [7:0]  TILT_LOW_RESET  = 8'd75;
  localparam logic [8:0]  HELD_X_RESET    = 9'd1;
  localparam logic [7:0]  LAST_Y_RESET    = 8'd2;
  localparam logic [15:0] STILL_MAX       = 16'hFFFF;

  localparam logic signed [3:0] TILT_STEP = 4'sd3;

  typedef enum logic [1:0] {
    REG_TARGET_SIGNATURE = 2'd0,
    REG_LOCK_LIMIT       = 2'd1,
    REG_TILT_HIGH        = 2'd2,
    REG_TILT_LOW         = 2'd3
  } cfg_reg_t;

  // pan step from the x band; the band around the image center is a dead band
  function automatic logic signed [3:0] pan_step(input logic [8:0] x);
    logic signed [3:0] s;
    begin
      if (x > 9'h118)       s = 4'sd6;
      else if (x > 9'h0FA)  s = 4'sd5;
      else if (x > 9'h0DC)  s = 4'sd3;
      else if (x > 9'h0BE)  s = 4'sd2;
      else if (x > 9'h0AA)  s = 4'sd1;
      else if (x >= 9'h096) s = 4'sd0;
      else if (x >= 9'h082) s = -4'sd1;
      else if (x >= 9'h064) s = -4'sd2;
      else if (x >= 9'h046) s = -4'sd3;
      else if (x >= 9'h028) s = -4'sd5;
      else                  s = -4'sd6;
      return s;
    end
  endfunction

  function automatic logic [PULSE_BITS-1:0] clamp_pulse(input logic signed [CALC_W-1:0] v);
    logic [PULSE_BITS-1:0] r;
    begin
      if (v < 0)                                     r = '0;
      else if (v > signed'(CALC_W'(PULSE_MAX)))      r = PULSE_MAX;
      else                                           r = v[PULSE_BITS-1:0];
      return r;
    end
  endfunction

  function automatic logic signed [CALC_W-1:0] offset(input logic [OUT_W-1:0] base,
                                                      input logic signed [3:0] step);
    begin
      return signed'(CALC_W'(base)) + {{(CALC_W-4){step[3]}}, step};
    end
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [PULSE_BITS-1:0] p);
    logic [CALC_W-1:0] e;
    begin
      e = CALC_W'(p);
      return e[OUT_W-1:0];
    end
  endfunction

endpackage

### rtl/pan_tilt_banded_tracking_servo.sv
// top level of the pan/tilt tracking servo: input register, tracking step, result register
`timescale 1ns / 1ps
//
// channel | handshake          | payload
// --------+--------------------+----------------------------------------------------
// in      | in_valid, in_stall | signature, obj_x, obj_y, pan_now, tilt_now
// out     | out_valid,out_stall| write_pulses, pan_pulse, tilt_pulse, locked, lock_led
// cfg     | cfg_we             | cfg_index, cfg_data
//
// one item per cycle while out_stall is low; an item that is taken goes through the input register,
// then the compare/add step into the result register
// the input register keeps taking an item while a finished result waits to be taken
// a stalled output holds the result and the input register; in_stall rises only
// when both are full
// rst clears tracking state, configuration and both valid flags

module pan_tilt_banded_tracking_servo (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  signature,
  input  logic [8:0]  obj_x,
  input  logic [7:0]  obj_y,
  input  logic [9:0]  pan_now,
  input  logic [9:0]  tilt_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_pulses,
  output logic [9:0]  pan_pulse,
  output logic [9:0]  tilt_pulse,
  output logic        locked,
  output logic        lock_led,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [2:0]  target_signature;
  logic [15:0] lock_limit;
  logic [7:0]  tilt_high;
  logic [7:0]  tilt_low;

  // tracking state
  logic                              sample_phase;
  logic [8:0]                        last_x;
  logic [8:0]                        held_x;
  logic [7:0]                        last_y;
  logic [15:0]                       still_count;
  logic [ptbts_pkg::PULSE_BITS-1:0]  pan_target;
  logic [ptbts_pkg::PULSE_BITS-1:0]  tilt_target;
  logic                              led_state;

  // input register
  logic       iv;
  logic [2:0] i_sig;
  logic [8:0] i_x;
  logic [7:0] i_y;
  logic [9:0] i_pan;
  logic [9:0] i_tilt;

  logic advance;
  logic in_take;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = iv && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_take) begin
      iv <= 1'b1;
    end else if (advance) begin
      iv <= 1'b0;
    end
    if (in_take) begin
      i_sig  <= signature;
      i_x    <= obj_x;
      i_y    <= obj_y;
      i_pan  <= pan_now;
      i_tilt <= tilt_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_signature <= ptbts_pkg::SIG_RESET;
      lock_limit       <= ptbts_pkg::LOCK_RESET;
      tilt_high        <= ptbts_pkg::TILT_HIGH_RESET;
      tilt_low         <= ptbts_pkg::TILT_LOW_RESET;
    end else if (cfg_we) begin
      unique case (ptbts_pkg::cfg_reg_t'(cfg_index))
        ptbts_pkg::REG_TARGET_SIGNATURE: target_signature <= cfg_data[2:0];
        ptbts_pkg::REG_LOCK_LIMIT:       lock_limit       <= cfg_data;
        ptbts_pkg::REG_TILT_HIGH:        tilt_high        <= cfg_data[7:0];
        ptbts_pkg::REG_TILT_LOW:         tilt_low         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // tracking step
  logic                              sample_phase_next;
  logic [8:0]                        last_x_next;
  logic [8:0]                        held_x_next;
  logic [7:0]                        last_y_next;
  logic [15:0]                       still_count_next;
  logic [ptbts_pkg::PULSE_BITS-1:0]  pan_target_next;
  logic [ptbts_pkg::PULSE_BITS-1:0]  tilt_target_next;
  logic                              led_state_next;
  logic                              wr_next;
  logic                              lk_next;

  logic              match;
  logic              sampling;
  logic              still_inc;
  logic [15:0]       still_plus;
  logic              stop;
  logic signed [3:0] step;

  always_comb begin
    match      = (i_sig == target_signature);
    sampling   = iv && match && sample_phase;
    still_inc  = (still_count != 16'd0) && (held_x == i_x);
    still_plus = (still_count < ptbts_pkg::STILL_MAX) ? still_count + 16'd1 : still_count;
    step       = ptbts_pkg::pan_step(i_x);

    sample_phase_next = sample_phase;
    last_x_next       = last_x;
    held_x_next       = held_x;
    last_y_next       = last_y;
    still_count_next  = still_count;
    pan_target_next   = pan_target;
    tilt_target_next  = tilt_target;
    led_state_next    = led_state;
    stop              = 1'b0;
    lk_next           = 1'b0;
    wr_next           = 1'b0;

    if (sampling) begin
      last_x_next = i_x;
      last_y_next = i_y;
      if (still_inc) begin
        still_count_next = still_plus;
        stop             = (still_plus >= lock_limit);
      end else if (i_x == last_x) begin
        held_x_next      = last_x;
        still_count_next = 16'd1;
      end else begin
        still_count_next = 16'd0;
      end
      if (stop) begin
        led_state_next    = !led_state;
        lk_next           = 1'b1;
        sample_phase_next = 1'b0;
      end else begin
        if (i_x == 9'd0) begin
          pan_target_next = ptbts_pkg::clamp_pulse(ptbts_pkg::offset(i_pan, 4'sd0));
        end
        if ((i_x != last_x) && (step != 4'sd0)) begin
          pan_target_next = ptbts_pkg::clamp_pulse(ptbts_pkg::offset(i_pan, step));
        end
        if (i_y == 8'd0) begin
          tilt_target_next = ptbts_pkg::clamp_pulse(ptbts_pkg::offset(i_tilt, 4'sd0));
        end
        if (i_y != last_y) begin
          // low side wins when the window is inverted
          if (i_y < tilt_low) begin
            tilt_target_next = ptbts_pkg::clamp_pulse(
                ptbts_pkg::offset(i_tilt, -ptbts_pkg::TILT_STEP));
          end else if (i_y > tilt_high) begin
            tilt_target_next = ptbts_pkg::clamp_pulse(
                ptbts_pkg::offset(i_tilt, ptbts_pkg::TILT_STEP));
          end
        end
      end
    end

    // a matching item that does not lock always ends ready to sample again
    if (iv && match && !stop) begin
      wr_next           = (still_count_next == 16'd0);
      sample_phase_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_phase <= 1'b1;
      last_x       <= 9'd0;
      held_x       <= ptbts_pkg::HELD_X_RESET;
      last_y       <= ptbts_pkg::LAST_Y_RESET;
      still_count  <= 16'd0;
      pan_target   <= ptbts_pkg::PULSE_RESET;
      tilt_target  <= ptbts_pkg::PULSE_RESET;
      led_state    <= 1'b0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      out_valid <= iv;
      if (iv) begin
        sample_phase <= sample_phase_next;
        last_x       <= last_x_next;
        held_x       <= held_x_next;
        last_y       <= last_y_next;
        still_count  <= still_count_next;
        pan_target   <= pan_target_next;
        tilt_target  <= tilt_target_next;
        led_state    <= led_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && iv) begin
      write_pulses <= wr_next;
      pan_pulse    <= wr_next ? ptbts_pkg::to_out(pan_target_next) : 10'd0;
      tilt_pulse   <= wr_next ? ptbts_pkg::to_out(tilt_target_next) : 10'd0;
      locked       <= lk_next;
      lock_led     <= led_state_next;
    end
  end

endmodule
